[sv/grouped_int8_dot_product_top_defines.svh]
// assertion macros for the grouped int8 dot product block
`ifndef GROUPED_INT8_DOT_PRODUCT_TOP_DEFINES_SVH
`define GROUPED_INT8_DOT_PRODUCT_TOP_DEFINES_SVH

// condition in one cycle implies consequence in the next, outside reset
`define GI8DP_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

// consequence holds in the cycle after a reset cycle
`define GI8DP_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

[sv/gi8dp_pkg.sv]
`default_nettype none
package gi8dp_pkg;

  localparam int GROUP_SIZE      = 32;
  localparam int LANES           = 4;
  localparam int FIELD_LANES     = 4;
  localparam int NL              = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;
  localparam int ITEMS_PER_GROUP = ((GROUP_SIZE / LANES) > 0) ? (GROUP_SIZE / LANES) : 1;
  localparam int CNT_W           = (ITEMS_PER_GROUP > 1) ? $clog2(ITEMS_PER_GROUP) : 1;
  localparam int GSUM_W          = $clog2(ITEMS_PER_GROUP * NL * 16384) + 2;

  localparam int DATA_W   = 8;
  localparam int SCALE_W  = 32;
  localparam int FRAC_W   = 24;
  localparam int PROD_W   = 2 * SCALE_W;
  localparam int RSCALE_W = PROD_W - FRAC_W;
  localparam int TERM_W   = GSUM_W + RSCALE_W + 1;
  localparam int ACC_W    = 64;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                     close;
    logic                     last;
    logic signed [GSUM_W-1:0] gsum;
    logic [SCALE_W-1:0]       act_scale;
    logic [SCALE_W-1:0]       wt_scale;
  } gi8dp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gi8dp_qstat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_RND,
    B_TERM,
    B_ACC,
    B_EMIT
  } gi8dp_back_state_t;

endpackage
`default_nettype wire

[sv/gi8dp_front.sv]
`default_nettype none
module gi8dp_front import gi8dp_pkg::*; (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [FIELD_LANES-1:0][DATA_W-1:0]      act,
  input  logic [FIELD_LANES-1:0][DATA_W-1:0]      wt,
  input  logic [SCALE_W-1:0]                      act_scale,
  input  logic [SCALE_W-1:0]                      wt_scale,
  input  logic                                    last_in_row,
  input  gi8dp_qstat_t                            qstat,
  output logic                                    push,
  output gi8dp_entry_t                            entry
);

  logic signed [GSUM_W-1:0]     group_sum;
  logic [CNT_W-1:0]             lane_count;
  logic signed [2*DATA_W-1:0]   lane_prod [NL];
  logic signed [GSUM_W-1:0]     lane_sum;
  logic signed [GSUM_W-1:0]     group_sum_next;
  logic                         accept;
  logic                         close;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_prod[i] = $signed(act[i]) * $signed(wt[i]);
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < NL; i++) begin
      lane_sum = lane_sum + GSUM_W'(lane_prod[i]);
    end
  end

  assign group_sum_next = group_sum + lane_sum;
  assign in_stall       = qstat.full;
  assign accept         = in_valid && !qstat.full;
  assign close          = (lane_count == CNT_W'(ITEMS_PER_GROUP - 1));
  assign push           = accept && (close || last_in_row);

  assign entry.close     = close;
  assign entry.last      = last_in_row;
  assign entry.gsum      = group_sum_next;
  assign entry.act_scale = act_scale;
  assign entry.wt_scale  = wt_scale;

  // a row that ends mid-group drops the open group
  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum  <= '0;
      lane_count <= '0;
    end else if (accept) begin
      if (close || last_in_row) begin
        group_sum  <= '0;
        lane_count <= '0;
      end else begin
        group_sum  <= group_sum_next;
        lane_count <= lane_count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/gi8dp_queue.sv]
`default_nettype none
module gi8dp_queue import gi8dp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  gi8dp_entry_t entry_in,
  input  logic         pop,
  output gi8dp_entry_t entry_out,
  output gi8dp_qstat_t qstat
);

  gi8dp_entry_t      slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign entry_out   = slots[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/gi8dp_back.sv]
`default_nettype none
module gi8dp_back import gi8dp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  gi8dp_entry_t             entry,
  input  gi8dp_qstat_t             qstat,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  row_sum,
  output logic                     row_saturated
);

  gi8dp_back_state_t        state;
  gi8dp_back_state_t        state_next;
  gi8dp_entry_t             work;
  logic [PROD_W-1:0]        prod;
  logic [RSCALE_W-1:0]      rscale;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  row_acc;
  logic                     sat_flag;
  logic signed [ACC_W:0]    acc_sum;
  logic signed [ACC_W-1:0]  acc_next;
  logic                     acc_ovf;
  logic                     emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          state_next = B_MUL;
        end
      end
      B_MUL:  state_next = B_RND;
      B_RND:  state_next = B_TERM;
      B_TERM: state_next = B_ACC;
      B_ACC:  state_next = work.last ? B_EMIT : B_IDLE;
      B_EMIT: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // saturating add of the group term
  always_comb begin
    acc_sum = $signed({row_acc[ACC_W-1], row_acc}) + (ACC_W + 1)'(term);
    acc_ovf = (acc_sum[ACC_W] != acc_sum[ACC_W-1]);
    if (!acc_ovf) begin
      acc_next = acc_sum[ACC_W-1:0];
    end else if (acc_sum[ACC_W]) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= entry;
    end
    if (state == B_MUL) begin
      prod <= PROD_W'(work.act_scale) * PROD_W'(work.wt_scale);
    end
    if (state == B_RND) begin
      rscale <= RSCALE_W'((prod + ROUND_BIAS) >> FRAC_W);
    end
    if (state == B_TERM) begin
      term <= $signed(work.gsum) * $signed({1'b0, rscale});
    end
    if (emit) begin
      row_sum       <= row_acc;
      row_saturated <= sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc   <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_ACC && work.close) begin
        row_acc  <= acc_next;
        sat_flag <= sat_flag | acc_ovf;
      end
      if (emit) begin
        row_acc   <= '0;
        sat_flag  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/grouped_int8_dot_product_top.sv]
// grouped int8 dot product: one row of a group-quantised int8 matrix-vector product
// input channel (in_valid / in_stall): four activation/weight int8 pairs per request,
// the two unsigned Q8.24 group scales (used on the request that closes a group) and
// last_in_row, which marks the final request of a row
// output channel (out_valid / out_stall): one result per row, row_sum as saturated
// signed Q40.24 and row_saturated, set if the row accumulator clamped
// the front stage adds the lane products into the group sum, one request per cycle
// while the queue is not full; only requests that close a group or end a row enter
// a four-entry queue; the back stage takes one queued entry at a time through pop,
// scale product, rounding, group term multiply and saturating accumulate; a row end
// adds the result register, which gives row_sum once the row-ending entry is through
// the front sustains one request per cycle while queued entries come no faster than
// the back stage retires them, else the queue fills and in_stall rises
// reset clears the group sum, lane count, queue, row accumulator and out_valid
// a stalled result holds in the output register; the back stage runs on to its next
// row end and waits there; the front keeps taking requests until the queue is full
`default_nettype none
module grouped_int8_dot_product_top import gi8dp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] act_a,
  input  logic signed [DATA_W-1:0] act_b,
  input  logic signed [DATA_W-1:0] act_c,
  input  logic signed [DATA_W-1:0] act_d,
  input  logic signed [DATA_W-1:0] wt_a,
  input  logic signed [DATA_W-1:0] wt_b,
  input  logic signed [DATA_W-1:0] wt_c,
  input  logic signed [DATA_W-1:0] wt_d,
  input  logic [SCALE_W-1:0]       act_scale,
  input  logic [SCALE_W-1:0]       wt_scale,
  input  logic                     last_in_row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [ACC_W-1:0]  row_sum,
  output logic                     row_saturated
);

  logic [FIELD_LANES-1:0][DATA_W-1:0] act_lanes;
  logic [FIELD_LANES-1:0][DATA_W-1:0] wt_lanes;
  gi8dp_qstat_t                       qstat;
  gi8dp_entry_t                       push_entry;
  gi8dp_entry_t                       pop_entry;
  logic                               push;
  logic                               pop;

  assign act_lanes = {act_d, act_c, act_b, act_a};
  assign wt_lanes  = {wt_d, wt_c, wt_b, wt_a};

  gi8dp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .act         (act_lanes),
    .wt          (wt_lanes),
    .act_scale   (act_scale),
    .wt_scale    (wt_scale),
    .last_in_row (last_in_row),
    .qstat       (qstat),
    .push        (push),
    .entry       (push_entry)
  );

  gi8dp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (push_entry),
    .pop       (pop),
    .entry_out (pop_entry),
    .qstat     (qstat)
  );

  gi8dp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .entry         (pop_entry),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_sum       (row_sum),
    .row_saturated (row_saturated)
  );

endmodule
`default_nettype wire

[sv/gi8dp_checker.sv]
`default_nettype none
`include "grouped_int8_dot_product_top_defines.svh"
module gi8dp_checker import gi8dp_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [ACC_W-1:0] row_sum,
  input wire logic                    row_saturated
);

  `GI8DP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `GI8DP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(row_sum) && $stable(row_saturated), "stalled result changed")
  `GI8DP_ASSERT_AFTER_RST(a_rst_out, !out_valid, "result present after reset")
  `GI8DP_ASSERT_AFTER_RST(a_rst_stall, !in_stall, "input stalled after reset")

endmodule

bind grouped_int8_dot_product_top gi8dp_checker u_checker (.*);
`default_nettype wire

[tb/tb_grouped_int8_dot_product_top.sv]
`default_nettype none
module tb_grouped_int8_dot_product_top import gi8dp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 30;
  localparam int N_DIRECTED = 5;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    sat;
  } row_res_t;

  typedef struct packed {
    int unsigned             reps;
    logic [31:0]             acts;
    logic [31:0]             wts;
    logic [SCALE_W-1:0]      a_scale;
    logic [SCALE_W-1:0]      w_scale;
    logic                    last;
    logic                    typed;
    logic signed [ACC_W-1:0] ref_sum;
    logic                    ref_sat;
  } stim_row_t;

  // lane 0 sits in the low byte; only the final repetition of a row carries last
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      64'sh0000_0000_0000_0000, 1'b0},
    '{8, 32'h8080_8080, 32'h8080_8080, 32'h0100_0000, 32'h0100_0000, 1'b1, 1'b1,
      64'sh0000_0800_0000_0000, 1'b0},
    '{8, 32'h7F7F_7F7F, 32'h8080_8080, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
      64'sh0, 1'b0},
    '{1, 32'h807F_01FF, 32'h7F80_FF01, 32'h0080_0000, 32'h0000_0001, 1'b1, 1'b0,
      64'sh0, 1'b0},
    '{7, 32'h7F7F_7F7F, 32'h7F7F_7F7F, 32'h0080_0000, 32'h0000_0001, 1'b1, 1'b1,
      64'sh0000_0000_0000_0000, 1'b0}
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] act_a, act_b, act_c, act_d;
  logic signed [DATA_W-1:0] wt_a, wt_b, wt_c, wt_d;
  logic [SCALE_W-1:0]       act_scale;
  logic [SCALE_W-1:0]       wt_scale;
  logic                     last_in_row;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ACC_W-1:0]  row_sum;
  logic                     row_saturated;

  grouped_int8_dot_product_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .act_a         (act_a),
    .act_b         (act_b),
    .act_c         (act_c),
    .act_d         (act_d),
    .wt_a          (wt_a),
    .wt_b          (wt_b),
    .wt_c          (wt_c),
    .wt_d          (wt_d),
    .act_scale     (act_scale),
    .wt_scale      (wt_scale),
    .last_in_row   (last_in_row),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_sum       (row_sum),
    .row_saturated (row_saturated)
  );

  // predictor state
  longint open_sum;
  int     open_items;
  longint row_q40;
  bit     row_clamped;

  row_res_t pending_rows [$];

  // typed expectation travelling with the request on the wire
  logic                    cur_typed;
  logic signed [ACC_W-1:0] cur_ref_sum;
  logic                    cur_ref_sat;

  int          in_gap_max;
  int          out_gap_max;
  bit          hold_long;
  int          sent_cnt;
  int          rows_checked;
  int          rows_clamped;
  int          mismatches;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void accumulate_request(input logic [31:0] acts, input logic [31:0] wts,
                                             input logic [SCALE_W-1:0] a_scale,
                                             input logic [SCALE_W-1:0] w_scale,
                                             input logic last, output bit row_done,
                                             output row_res_t res);
    logic [63:0] scale_prod;
    logic [63:0] scale_q24;
    longint      term;
    for (int i = 0; i < NL; i++)
      open_sum += longint'($signed(acts[8*i +: 8])) * longint'($signed(wts[8*i +: 8]));
    open_items++;
    if (open_items >= ITEMS_PER_GROUP) begin
      scale_prod = 64'(a_scale) * 64'(w_scale);
      scale_q24 = (scale_prod + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
      term = open_sum * longint'(scale_q24);
      if (term > 0 && row_q40 > ACC_MAX - term) begin
        row_q40 = ACC_MAX;
        row_clamped = 1'b1;
      end else if (term < 0 && row_q40 < ACC_MIN - term) begin
        row_q40 = ACC_MIN;
        row_clamped = 1'b1;
      end else begin
        row_q40 += term;
      end
      open_sum = 0;
      open_items = 0;
    end
    row_done = last;
    res.sum = row_q40;
    res.sat = row_clamped;
    if (last) begin
      open_sum = 0;
      open_items = 0;
      row_q40 = 0;
      row_clamped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    row_res_t want;
    row_res_t got;
    bit       row_done;
    if (!rst && in_valid && !in_stall) begin
      accumulate_request({act_d, act_c, act_b, act_a}, {wt_d, wt_c, wt_b, wt_a},
                         act_scale, wt_scale, last_in_row, row_done, got);
      if (row_done) begin
        if (cur_typed) begin
          got.sum = cur_ref_sum;
          got.sat = cur_ref_sat;
        end
        pending_rows.push_back(got);
      end
    end
    if (!rst && out_valid && !out_stall) begin
      rows_checked++;
      if (row_saturated)
        rows_clamped++;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result: row_sum %h row_saturated %0b",
                   row_sum, row_saturated);
      end else begin
        want = pending_rows.pop_front();
        if (row_sum !== want.sum || row_saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: row_sum exp %h got %h, row_saturated exp %0b got %0b",
                     rows_checked, want.sum, row_sum, want.sat, row_saturated);
        end
      end
    end
  end

  always @(posedge clk)
    cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt == CYCLE_LIMIT);
    $display("tb_grouped_int8_dot_product_top: done, errors");
    $finish;
  end

  function automatic logic [31:0] rand_lanes();
    case ($urandom_range(0, 7))
      0: return 32'h8080_8080;
      1: return 32'h7F7F_7F7F;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SCALE_W'($urandom_range(0, 255));
      3: return 32'h0100_0000 + SCALE_W'($urandom_range(0, 32'h00FF_FFFF));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [31:0] acts, input logic [31:0] wts,
                           input logic [SCALE_W-1:0] a_scale,
                           input logic [SCALE_W-1:0] w_scale,
                           input logic last, input logic typed,
                           input logic signed [ACC_W-1:0] ref_sum, input logic ref_sat);
    int gap;
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    act_a       <= acts[7:0];
    act_b       <= acts[15:8];
    act_c       <= acts[23:16];
    act_d       <= acts[31:24];
    wt_a        <= wts[7:0];
    wt_b        <= wts[15:8];
    wt_c        <= wts[23:16];
    wt_d        <= wts[31:24];
    act_scale   <= a_scale;
    wt_scale    <= w_scale;
    last_in_row <= last;
    cur_typed   <= typed;
    cur_ref_sum <= ref_sum;
    cur_ref_sat <= ref_sat;
    do @(posedge clk); while (in_stall);
    sent_cnt++;
  endtask

  task automatic send_random_row(input int max_groups);
    int n_items;
    if (max_groups == 0) begin
      n_items = $urandom_range(1, 3);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n_items = ITEMS_PER_GROUP * $urandom_range(1, max_groups);
        6, 7, 8: n_items = ITEMS_PER_GROUP * $urandom_range(0, max_groups - 1)
                           + $urandom_range(1, ITEMS_PER_GROUP - 1);
        default: n_items = 1;
      endcase
    end
    for (int k = 0; k < n_items; k++)
      send_item(rand_lanes(), rand_lanes(), rand_scale(), rand_scale(),
                k == n_items - 1, 1'b0, '0, 1'b0);
  endtask

  // full-scale groups that drive the row accumulator into its clamp
  task automatic send_heavy_row(input int up_groups, input int down_groups);
    logic [SCALE_W-1:0] sc;
    int                 n_groups;
    n_groups = up_groups + down_groups;
    for (int g = 0; g < n_groups; g++)
      for (int k = 0; k < ITEMS_PER_GROUP; k++) begin
        sc = 32'hFFFF_0000 | SCALE_W'($urandom_range(0, 32'hFFFF));
        send_item((g < up_groups) ? 32'h8080_8080 : 32'h7F7F_7F7F, 32'h8080_8080, sc, sc,
                  (g == n_groups - 1) && (k == ITEMS_PER_GROUP - 1), 1'b0, '0, 1'b0);
      end
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rows.size() != 0);
  endtask

  // receiver: random back-pressure per row result, plus one long hold on request
  initial begin
    int n;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    bit is_end;
    open_sum     = 0;
    open_items   = 0;
    row_q40      = 0;
    row_clamped  = 1'b0;
    hold_long    = 1'b0;
    sent_cnt     = 0;
    rows_checked = 0;
    rows_clamped = 0;
    mismatches   = 0;
    in_gap_max   = 5;
    out_gap_max  = 5;
    in_valid    <= 1'b0;
    act_a       <= '0;
    act_b       <= '0;
    act_c       <= '0;
    act_d       <= '0;
    wt_a        <= '0;
    wt_b        <= '0;
    wt_c        <= '0;
    wt_d        <= '0;
    act_scale   <= '0;
    wt_scale    <= '0;
    last_in_row <= 1'b0;
    cur_typed   <= 1'b0;
    cur_ref_sum <= '0;
    cur_ref_sat <= 1'b0;
    rst         <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++)
      for (int k = 0; k < int'(DIRECTED[r].reps); k++) begin
        is_end = DIRECTED[r].last && (k == int'(DIRECTED[r].reps) - 1);
        send_item(DIRECTED[r].acts, DIRECTED[r].wts, DIRECTED[r].a_scale,
                  DIRECTED[r].w_scale, is_end, DIRECTED[r].typed && is_end,
                  DIRECTED[r].ref_sum, DIRECTED[r].ref_sat);
      end
    drain_rows();

    while (sent_cnt < 300)
      send_random_row(4);

    // no idling on either side
    in_gap_max  = 0;
    out_gap_max = 0;
    while (sent_cnt < 430)
      send_random_row(3);
    drain_rows();

    // short rows back to back while the receiver holds off
    out_gap_max = 5;
    hold_long   = 1'b1;
    for (int i = 0; i < 40; i++)
      send_random_row(0);
    drain_rows();

    in_gap_max = 2;
    send_heavy_row(18, 2);
    send_heavy_row(0, 18);
    drain_rows();

    in_gap_max  = 5;
    out_gap_max = 0;
    while (sent_cnt < 920)
      send_random_row(4);
    drain_rows();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests (directed, random rows, back-pressure burst, clamping rows)",
             sent_cnt);
    $display("%0d row results checked, %0d clamped, %0d mismatches",
             rows_checked, rows_clamped, mismatches);
    if (mismatches == 0)
      $display("tb_grouped_int8_dot_product_top: done, clean");
    else
      $display("tb_grouped_int8_dot_product_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/gi8dp_pkg.sv
sv/gi8dp_front.sv
sv/gi8dp_queue.sv
sv/gi8dp_back.sv
sv/grouped_int8_dot_product_top.sv
sv/gi8dp_checker.sv
tb/tb_grouped_int8_dot_product_top.sv
